>>> sv/ncdf_pkg.sv
// ncdf_pkg: shared constants, types and pipeline latencies for normal_cdf_approx.
// Used by every module of the block; depends on nothing.
package ncdf_pkg;

    typedef logic [15:0]        len_t;      // |x|, unsigned Q4.12, up to 8.0
    typedef logic [24:0]        k_t;        // 1/(1+pL), Q1.24, up to 1.0
    typedef logic signed [28:0] poly_t;     // Horner accumulator, signed Q.24
    typedef logic [32:0]        expv_t;     // exp(-L*L/2), Q.30
    typedef logic [31:0]        dens_t;     // density, Q.30

    localparam logic [21:0] P_Q24            = 22'd3886306;
    localparam poly_t       B1_Q24           = 29'sd5358333;
    localparam poly_t       B2_Q24           = -29'sd5982148;
    localparam poly_t       B3_Q24           = 29'sd29888240;
    localparam poly_t       B4_Q24           = -29'sd30555605;
    localparam poly_t       B5_Q24           = 29'sd22318301;
    localparam logic [29:0] LN2_Q30          = 30'd744261118;
    localparam logic [28:0] INV_SQRT_2PI_Q30 = 29'd428361012;
    localparam int          TAYLOR_TERMS     = 13;

    // Stage counts of the sub-units, request in to result out
    localparam int RECIP_LAT  = 26;
    localparam int HORNER_LAT = 10;
    localparam int EXP_LAT    = 48;
    // Edges from the edge that takes a request to the edge that takes its result
    localparam int TOTAL_LAT  = EXP_LAT + 4;

    // Coefficient added after Horner step i (none after the last)
    function automatic poly_t horner_coef(input int i);
        poly_t c;
        case (i)
            0:       c = B4_Q24;
            1:       c = B3_Q24;
            2:       c = B2_Q24;
            3:       c = B1_Q24;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

>>> sv/normal_cdf_approx.sv
// normal_cdf_approx: top level, fixed-point cumulative standard normal Phi(x).
// Uses ncdf_pkg, ncdf_recip, ncdf_horner and ncdf_exp.
//
// Usage:
//  - Request channel: x_value (signed Q4.12) is taken at a rising edge with
//    start high and busy low. busy is always low, so a request may be issued
//    in every cycle.
//  - Result channel: probability (unsigned Q0.16, saturated at 65535) is shown
//    for one cycle with done high; the receiver cannot stall and must take it.
//  - Pipeline: the depth from request to done is set by the exp unit (range
//    reduction plus three stages for each of the 13 Taylor terms). The
//    reciprocal divider and Horner unit run alongside and their result is
//    delayed to line up.
//  - Throughput: one request per cycle, results in request order.
//  - Reset: rst_n clears all valid bits; requests in flight are dropped and
//    no done is produced until new requests arrive.
module normal_cdf_approx (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [15:0] x_value,
    output logic        done,
    output logic [15:0] probability
);
    import ncdf_pkg::*;

    localparam int PD    = EXP_LAT + 1 - RECIP_LAT - HORNER_LAT;
    localparam int NEG_D = EXP_LAT + 1;

    logic [15:0] x_reg;
    logic        v0_reg;
    len_t        len0;
    logic        neg0;

    logic        k_valid;
    k_t          k;
    logic        p_valid;
    poly_t       poly;
    logic        e_valid;
    expv_t       ex;

    dens_t       dens_reg;
    logic        dv_reg;
    poly_t       pd_reg [0:PD-1];
    logic [PD-1:0]    pdv_reg;
    logic [NEG_D-1:0] neg_line;

    logic [59:0] tprod_reg;
    logic        tneg_reg;
    logic        tv_reg;

    logic [62:0] dprod;
    logic [60:0] trnd;
    logic [22:0] tail_raw;
    logic [16:0] tail;
    logic [16:0] res;

    logic [15:0] prob_reg;
    logic        done_reg;

    assign busy = 1'b0;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_value;
    end

    // |x| and sign; -8.0 gives exactly 32768
    assign neg0 = x_reg[15];
    assign len0 = neg0 ? 16'(17'h10000 - 17'(x_reg)) : x_reg;

    ncdf_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .len       (len0),
        .out_valid (k_valid),
        .k         (k)
    );

    ncdf_horner u_horner (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (k_valid),
        .k         (k),
        .out_valid (p_valid),
        .poly      (poly)
    );

    ncdf_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .len       (len0),
        .out_valid (e_valid),
        .ex        (ex)
    );

    // Density = exp * 1/sqrt(2 pi), rounded
    assign dprod = (63'(ex) * 63'(INV_SQRT_2PI_Q30)) + (63'd1 << 29);

    // Alignment of polynomial and sign with the density
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg  <= 1'b0;
            pdv_reg <= '0;
            tv_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            dv_reg   <= e_valid;
            pdv_reg  <= {pdv_reg[PD-2:0], p_valid};
            tv_reg   <= dv_reg;
            done_reg <= tv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dens_reg  <= dprod[61:30];
        pd_reg[0] <= poly;
        neg_line  <= {neg_line[NEG_D-2:0], neg0};
    end

    for (genvar i = 1; i < PD; i++)
    begin : g_pdelay
        always_ff @(posedge clk)
        begin
            pd_reg[i] <= pd_reg[i-1];
        end
    end

    // Tail product; a polynomial that is not positive gives no tail
    always_ff @(posedge clk)
    begin
        if (!pd_reg[PD-1][28] && (pd_reg[PD-1] != '0))
        begin
            tprod_reg <= 60'(dens_reg) * 60'(pd_reg[PD-1][27:0]);
        end
        else
        begin
            tprod_reg <= '0;
        end
        tneg_reg <= neg_line[NEG_D-1];
    end

    // Round, clamp, reflect and saturate
    assign trnd     = 61'(tprod_reg) + (61'd1 << 37);
    assign tail_raw = trnd[60:38];
    assign tail     = (tail_raw > 23'h10000) ? 17'h10000 : tail_raw[16:0];
    assign res      = tneg_reg ? tail : 17'h10000 - tail;

    always_ff @(posedge clk)
    begin
        prob_reg <= res[16] ? 16'hFFFF : res[15:0];
    end

    assign probability = prob_reg;
    assign done        = done_reg;

    // Every request gives exactly one result, a fixed latency later
    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##TOTAL_LAT done)
        else $error("result missing after request");

    a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, TOTAL_LAT))
        else $error("result without matching request");

    // Delayed polynomial arrives with the density
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg == pdv_reg[PD-1])
        else $error("polynomial and density out of step");

endmodule

>>> sv/ncdf_recip.sv
// ncdf_recip: pipelined restoring divider giving k = round(2^60 / (2^36 + p*L)).
// One quotient bit per stage; depends on ncdf_pkg.
module ncdf_recip (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  ncdf_pkg::len_t len,
    output logic          out_valid,
    output ncdf_pkg::k_t  k
);
    import ncdf_pkg::*;

    localparam int STEPS = 25;
    localparam logic [38:0] D_BASE = 39'd1 << 36;
    localparam logic [38:0] R_BASE = 39'd1 << 35;

    logic [38:0] d_reg   [0:STEPS];
    logic [38:0] r_reg   [0:STEPS];
    logic [24:0] low_reg [0:STEPS];
    logic [24:0] q_reg   [0:STEPS];
    logic [STEPS:0] v_reg;

    logic [38:0] d_next;
    logic [38:0] half;

    // Divisor, and dividend 2^60 + D/2 split into a starting remainder and low bits
    assign d_next = D_BASE + (39'(P_Q24) * 39'(len));
    assign half   = d_next >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg[0]   <= d_next;
        r_reg[0]   <= R_BASE + 39'(half[37:25]);
        low_reg[0] <= half[24:0];
        q_reg[0]   <= '0;
    end

    // One compare and subtract per stage
    for (genvar s = 1; s <= STEPS; s++)
    begin : g_step
        localparam int B = STEPS - s;
        logic [39:0] trial;
        logic        ge;
        assign trial = {r_reg[s-1], low_reg[s-1][B]};
        assign ge    = trial >= {1'b0, d_reg[s-1]};

        always_ff @(posedge clk)
        begin
            d_reg[s]   <= d_reg[s-1];
            low_reg[s] <= low_reg[s-1];
            r_reg[s]   <= ge ? 39'(trial - {1'b0, d_reg[s-1]}) : trial[38:0];
            q_reg[s]   <= {q_reg[s-1][23:0], ge};
        end
    end

    assign k         = q_reg[STEPS];
    assign out_valid = v_reg[STEPS];

endmodule

>>> sv/ncdf_horner.sv
// ncdf_horner: five-step Horner polynomial in k, multiply then round-and-add per step.
// Depends on ncdf_pkg.
module ncdf_horner (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  ncdf_pkg::k_t   k,
    output logic           out_valid,
    output ncdf_pkg::poly_t poly
);
    import ncdf_pkg::*;

    localparam int STEPS = 5;

    logic [52:0] prod_reg [0:STEPS-1];
    logic        neg_reg  [0:STEPS-1];
    k_t          ka_reg   [0:STEPS-1];
    k_t          kb_reg   [0:STEPS-1];
    poly_t       p_reg    [0:STEPS-1];
    logic [STEPS-1:0] va_reg;
    logic [STEPS-1:0] vb_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        poly_t       p_in;
        k_t          k_in;
        logic        v_in;
        logic [27:0] mag;
        logic [52:0] rnd;
        logic [28:0] m;
        poly_t       sp;

        if (i == 0)
        begin : g_first
            assign p_in = B5_Q24;
            assign k_in = k;
            assign v_in = in_valid;
        end
        else
        begin : g_next
            assign p_in = p_reg[i-1];
            assign k_in = kb_reg[i-1];
            assign v_in = vb_reg[i-1];
        end

        // Magnitude times k
        assign mag = p_in[28] ? 28'(-p_in) : p_in[27:0];

        // Round half away from zero, restore sign, add next coefficient
        assign rnd = prod_reg[i] + (53'd1 << 23);
        assign m   = {1'b0, rnd[51:24]};
        assign sp  = neg_reg[i] ? -signed'(m) : signed'(m);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg[i] <= 1'b0;
                vb_reg[i] <= 1'b0;
            end
            else
            begin
                va_reg[i] <= v_in;
                vb_reg[i] <= va_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            prod_reg[i] <= 53'(mag) * 53'(k_in);
            neg_reg[i]  <= p_in[28];
            ka_reg[i]   <= k_in;
            kb_reg[i]   <= ka_reg[i];
            p_reg[i]    <= sp + horner_coef(i);
        end
    end

    assign poly      = p_reg[STEPS-1];
    assign out_valid = vb_reg[STEPS-1];

endmodule

>>> sv/ncdf_exp.sv
// ncdf_exp: pipelined exp(-L*L/2) in Q.30 by ln 2 range reduction and a Taylor series.
// Depends on ncdf_pkg.
module ncdf_exp (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  ncdf_pkg::len_t len,
    output logic           out_valid,
    output ncdf_pkg::expv_t ex
);
    import ncdf_pkg::*;

    localparam int NB = 6;  // quotient bits of u / ln 2 (below 64)
    localparam int NT = TAYLOR_TERMS;

    // Range reduction chain
    logic [35:0]   rr_reg [0:NB];
    logic [NB-1:0] n_reg  [0:NB];
    logic [NB:0]   vr_reg;

    // Taylor chain: three stages per term
    logic [29:0]   a_t   [1:NT];
    logic [29:0]   a_r   [1:NT];
    logic [NB-1:0] a_n   [1:NT];
    logic [32:0]   a_pos [1:NT];
    logic [32:0]   a_neg [1:NT];
    logic [29:0]   b_q   [1:NT];
    logic [29:0]   b_t   [1:NT];
    logic [29:0]   b_r   [1:NT];
    logic [NB-1:0] b_n   [1:NT];
    logic [32:0]   b_pos [1:NT];
    logic [32:0]   b_neg [1:NT];
    logic [30:0]   c_term[1:NT];
    logic [29:0]   c_r   [1:NT];
    logic [NB-1:0] c_n   [1:NT];
    logic [32:0]   c_pos [1:NT];
    logic [32:0]   c_neg [1:NT];
    logic [NT:1]   va_reg;
    logic [NT:1]   vb_reg;
    logic [NT:1]   vc_reg;

    // Tail stages
    logic [32:0]   e_reg;
    logic [NB-1:0] en_reg;
    logic          ve_reg;
    expv_t         ex_reg;
    logic          vx_reg;

    logic [31:0] len_sq;
    assign len_sq = 32'(len) * 32'(len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg <= '0;
        end
        else
        begin
            vr_reg <= {vr_reg[NB-1:0], in_valid};
        end
    end

    // u = L*L/2 in Q.30
    always_ff @(posedge clk)
    begin
        rr_reg[0] <= {len_sq[30:0], 5'd0};
        n_reg[0]  <= '0;
    end

    // n = floor(u / ln 2), one bit per stage
    for (genvar s = 1; s <= NB; s++)
    begin : g_range
        localparam logic [35:0] SUB = 36'(LN2_Q30) << (NB - s);
        logic ge;
        assign ge = rr_reg[s-1] >= SUB;

        always_ff @(posedge clk)
        begin
            rr_reg[s] <= ge ? rr_reg[s-1] - SUB : rr_reg[s-1];
            n_reg[s]  <= {n_reg[s-1][NB-2:0], ge};
        end
    end

    for (genvar j = 1; j <= NT; j++)
    begin : g_term
        localparam logic [32:0] M  = 33'((64'd1 << 32) / j);
        localparam logic [3:0]  JC = 4'(j);
        logic [30:0]   s_term;
        logic [29:0]   s_r;
        logic [NB-1:0] s_n;
        logic [32:0]   s_pos;
        logic [32:0]   s_neg;
        logic          s_v;
        logic [60:0]   prod;
        logic [62:0]   qprod;
        logic [33:0]   rem;
        logic [30:0]   term;

        if (j == 1)
        begin : g_first
            assign s_term = 31'd1 << 30;
            assign s_r    = rr_reg[NB][29:0];
            assign s_n    = n_reg[NB];
            assign s_pos  = 33'd1 << 30;
            assign s_neg  = '0;
            assign s_v    = vr_reg[NB];
        end
        else
        begin : g_next
            assign s_term = c_term[j-1];
            assign s_r    = c_r[j-1];
            assign s_n    = c_n[j-1];
            assign s_pos  = c_pos[j-1];
            assign s_neg  = c_neg[j-1];
            assign s_v    = vc_reg[j-1];
        end

        // term * r, back to Q.30
        assign prod  = 61'(s_term) * 61'(s_r);
        // Divide by j: reciprocal estimate, then one correction
        assign qprod = 63'(a_t[j]) * 63'(M);
        assign rem   = 34'(b_t[j]) - (34'(b_q[j]) * 34'(JC));
        assign term  = 31'(b_q[j]) + ((rem >= 34'(JC)) ? 31'd1 : 31'd0);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg[j] <= 1'b0;
                vb_reg[j] <= 1'b0;
                vc_reg[j] <= 1'b0;
            end
            else
            begin
                va_reg[j] <= s_v;
                vb_reg[j] <= va_reg[j];
                vc_reg[j] <= vb_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            a_t[j]   <= prod[59:30];
            a_r[j]   <= s_r;
            a_n[j]   <= s_n;
            a_pos[j] <= s_pos;
            a_neg[j] <= s_neg;

            b_q[j]   <= qprod[61:32];
            b_t[j]   <= a_t[j];
            b_r[j]   <= a_r[j];
            b_n[j]   <= a_n[j];
            b_pos[j] <= a_pos[j];
            b_neg[j] <= a_neg[j];

            c_term[j] <= term;
            c_r[j]    <= b_r[j];
            c_n[j]    <= b_n[j];
            // odd terms subtract, even terms add
            if ((j % 2) == 1)
            begin
                c_pos[j] <= b_pos[j];
                c_neg[j] <= b_neg[j] + 33'(term);
            end
            else
            begin
                c_pos[j] <= b_pos[j] + 33'(term);
                c_neg[j] <= b_neg[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg <= 1'b0;
            vx_reg <= 1'b0;
        end
        else
        begin
            ve_reg <= vc_reg[NT];
            vx_reg <= ve_reg;
        end
    end

    // exp(-r) floored at zero, then scaled by 2^-n
    always_ff @(posedge clk)
    begin
        e_reg  <= (c_pos[NT] > c_neg[NT]) ? c_pos[NT] - c_neg[NT] : '0;
        en_reg <= c_n[NT];
        ex_reg <= e_reg >> en_reg;
    end

    assign ex        = ex_reg;
    assign out_valid = vx_reg;

endmodule

>>> verif/ncdf_checker.sv
// ncdf_checker: watches the request and result channels of normal_cdf_approx,
// predicts each probability from the accepted argument and compares in order.
// Depends on nothing outside this file.
module ncdf_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [15:0] x_value,
    input  logic        done,
    input  logic [15:0] probability,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    localparam longint P_Q24       = 3886306;
    localparam longint B1_Q24      = 5358333;
    localparam longint B2_Q24      = -5982148;
    localparam longint B3_Q24      = 29888240;
    localparam longint B4_Q24      = -30555605;
    localparam longint B5_Q24      = 22318301;
    localparam longint LN2_Q30     = 744261118;
    localparam longint INV_S2PI_Q30 = 428361012;
    localparam int     EXP_TERMS   = 13;

    logic [15:0] expected_prob[$];

    // Horner product: magnitude times k, rounded half away from zero to Q.24
    function automatic longint mul_k(input longint a, input longint k);
        longint m;
        m = (a < 0) ? -a : a;
        m = (m * k + (longint'(1) << 23)) >>> 24;
        return (a < 0) ? -m : m;
    endfunction

    // exp(-u), u and result in Q.30, by range reduction and Taylor sum
    function automatic longint exp_neg(input longint u);
        longint n, r, term, pos, negs, e;
        n = u / LN2_Q30;
        r = u - n * LN2_Q30;
        term = longint'(1) << 30;
        pos = term;
        negs = 0;
        for (int j = 1; j <= EXP_TERMS; j++)
        begin
            term = ((term * r) >>> 30) / j;
            if (j % 2) negs += term;
            else pos += term;
        end
        e = (pos > negs) ? pos - negs : 0;
        if (n > 62) return 0;
        return e >>> n;
    endfunction

    function automatic logic [15:0] cdf_of(input logic [15:0] x);
        logic   neg;
        longint len, den, k, p, ex, dens, tail, res;
        neg  = x[15];
        len  = neg ? (longint'(65536) - x) : longint'(x);
        den  = (longint'(1) << 36) + P_Q24 * len;
        k    = ((longint'(1) << 60) + den / 2) / den;
        p    = B5_Q24;
        p    = mul_k(p, k) + B4_Q24;
        p    = mul_k(p, k) + B3_Q24;
        p    = mul_k(p, k) + B2_Q24;
        p    = mul_k(p, k) + B1_Q24;
        p    = mul_k(p, k);
        ex   = exp_neg((len * len) << 5);
        dens = (ex * INV_S2PI_Q30 + (longint'(1) << 29)) >>> 30;
        // dens*p fits below 2^63: dens < 2^29, p < 2^26
        tail = (p > 0) ? ((dens * p + (longint'(1) << 37)) >>> 38) : 0;
        if (tail > 65536) tail = 65536;
        res = neg ? tail : 65536 - tail;
        if (res > 65535) res = 65535;
        return res[15:0];
    endfunction

    // Request capture and result comparison
    always @(posedge clk)
    begin
        logic [15:0] want;
        if (!rst_n)
        begin
            fail_count <= 0;
            checked    <= 0;
        end
        else
        begin
            if (done)
            begin
                checked <= checked + 1;
                if (expected_prob.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result: probability=%0d", probability);
                end
                else
                begin
                    want = expected_prob.pop_front();
                    if (want !== probability)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected %0d got %0d", want, probability);
                    end
                end
            end
            if (start && !busy)
                expected_prob.push_back(cdf_of(x_value));
            pending <= expected_prob.size();
        end
    end

endmodule

>>> verif/tb_top.sv
// tb_top: stimulus and verdict for normal_cdf_approx.
// Depends on ncdf_pkg, the block and ncdf_checker.
module tb_top;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic signed [15:0] x_value;
    logic        done;
    logic [15:0] probability;
    int          fail_count, pending, checked;
    int          cycle_count;
    int          sent;

    localparam int RANDOM_REQS = 1030;
    localparam int CYCLE_LIMIT = 400000;

    normal_cdf_approx DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .x_value(x_value), .done(done), .probability(probability)
    );

    ncdf_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .x_value(x_value), .done(done), .probability(probability),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Timeout watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("normal_cdf_approx verification failed");
            $finish;
        end
    end

    // Issue one request, holding start until it is taken
    task automatic send_req(input logic [15:0] x);
        start   <= 1'b1;
        x_value <= x;
        @(posedge clk);
        while (busy) @(posedge clk);
        sent++;
    endtask

    // Random gap: mostly none or short, a few long
    task automatic idle_gap();
        int n, r;
        r = $urandom_range(0, 99);
        if (r < 50) n = 0;
        else if (r < 92) n = $urandom_range(1, 4);
        else n = $urandom_range(10, 70);
        if (n > 0)
        begin
            start <= 1'b0;
            x_value <= 16'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] rand_x();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 16'($urandom);
        if (r < 8) return 16'($signed($urandom_range(0, 24576)) - 12288);
        if (r < 9) return 16'($urandom_range(0, 15));
        return 16'(-$signed($urandom_range(0, 15)));
    endfunction

    initial
    begin
        logic [15:0] directed[$];
        int waited;
        sent = 0;
        start = 0;
        x_value = '0;
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero, extremes, tiny steps either side, and the saturation region
        directed = '{16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF,
                     16'h8001, 16'h7FFE, 16'h1000, 16'hF000, 16'h2000,
                     16'hE000, 16'h3000, 16'hD000, 16'h4000, 16'hC000,
                     16'h5000, 16'hB000, 16'h0800, 16'hF800, 16'h5555,
                     16'hAAAA};
        foreach (directed[i]) send_req(directed[i]);
        start <= 1'b0;
        repeat (20) @(posedge clk);

        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            if (i % 200 > 150) idle_gap();
            else if (i % 200 > 60) begin if ($urandom_range(0, 1)) idle_gap(); end
            send_req(rand_x());
        end
        start <= 1'b0;

        // Drain, then allow the block's latency for stray results
        waited = 0;
        while (pending != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (ncdf_pkg::TOTAL_LAT + 10) @(posedge clk);

        $display("Sent %0d requests (directed extremes plus random), %0d results checked.",
                 sent, checked);
        if (fail_count == 0 && pending == 0)
            $display("normal_cdf_approx verification clean");
        else
            $display("normal_cdf_approx verification failed");
        $finish;
    end

endmodule
